// ===== design/assert_macros.svh =====
// Assertion macros shared by the RTL of the strip to triangle assembler.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted
`define STAC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("stac assertion failed");
// Next-cycle implication, disabled while reset is asserted
`define STAC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("stac assertion failed");
`else
`define STAC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define STAC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/stac_pkg.sv =====
// Shared types and constants for the strip to triangle assembler.
// Depends on nothing; used by stac_cfg_regs, stac_core and the top level.
`timescale 1ns / 1ps

package stac_pkg;

	// APB register map
	localparam int unsigned ADDR_BITS = 3;
	localparam int unsigned DATA_BITS = 32;
	localparam logic [0:0]  REG_RESTART_INDEX = 1'b0;
	localparam logic [31:0] RESTART_DEFAULT   = 32'h0000_FFFF;

	// Load phase codes of the held pair
	localparam logic [1:0] PHASE_FIRST  = 2'd0;
	localparam logic [1:0] PHASE_SECOND = 2'd1;
	localparam logic [1:0] PHASE_RUN    = 2'd2;

	// Per-request decision of the assembly stage
	typedef struct packed {
		logic emit;        // request yields a triangle
		logic restart_hit; // restart value seen while running
	} step_status_t;

endpackage

// ===== design/stac_cfg_regs.sv =====
// APB configuration register (restart index) for the strip assembler.
// Depends on stac_pkg for the address map and reset value.
`timescale 1ns / 1ps

module stac_cfg_regs #(
	parameter int unsigned INDEX_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [stac_pkg::ADDR_BITS-1:0]     paddr,
	input  logic [stac_pkg::DATA_BITS-1:0]     pwdata,
	output logic [stac_pkg::DATA_BITS-1:0]     prdata,
	output logic                               pready,
	output logic [INDEX_BITS-1:0]              restart_index
);

	logic [INDEX_BITS-1:0] restart_q;
	logic                  sel_restart;
	logic                  wr_en;

	// Word decode: register index sits above the byte offset
	assign sel_restart = (paddr[stac_pkg::ADDR_BITS-1:2] == stac_pkg::REG_RESTART_INDEX);
	assign wr_en       = psel && penable && pwrite;
	assign pready      = 1'b1;

	// Restart index register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restart_q <= INDEX_BITS'(stac_pkg::RESTART_DEFAULT);
		end else if (wr_en && sel_restart) begin
			restart_q <= pwdata[INDEX_BITS-1:0];
		end
	end

	// Read back, zero above the index width
	always_comb begin
		prdata = '0;
		if (sel_restart) begin
			prdata = stac_pkg::DATA_BITS'(restart_q);
		end
	end

	assign restart_index = restart_q;

endmodule

// ===== design/stac_core.sv =====
// Held pair, load phase and winding state with the per-index assembly logic.
// Depends on stac_pkg for phase codes and the status struct.
`timescale 1ns / 1ps

module stac_core #(
	parameter int unsigned INDEX_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  advance,
	input  logic [INDEX_BITS-1:0] strip_index,
	input  logic                  strip_start,
	input  logic [INDEX_BITS-1:0] restart_index,
	output stac_pkg::step_status_t status,
	output logic [INDEX_BITS-1:0] tri_a,
	output logic [INDEX_BITS-1:0] tri_b,
	output logic [INDEX_BITS-1:0] tri_c
);

	logic [INDEX_BITS-1:0] older_q, newer_q;
	logic [1:0]            phase_q;
	logic                  winding_q;

	logic [INDEX_BITS-1:0] older_d, newer_d;
	logic [1:0]            phase_d;
	logic                  winding_d;
	logic                  distinct;

	assign distinct = (older_q != newer_q) && (newer_q != strip_index)
		&& (older_q != strip_index);

	// Corner order: odd positions a,b,c; even positions a,c,b
	assign tri_a = older_q;
	assign tri_b = winding_q ? strip_index : newer_q;
	assign tri_c = winding_q ? newer_q : strip_index;

	// Next state for the request at the head
	always_comb begin
		older_d            = older_q;
		newer_d            = newer_q;
		phase_d            = phase_q;
		winding_d          = winding_q;
		status.emit        = 1'b0;
		status.restart_hit = 1'b0;
		if (strip_start) begin
			older_d   = strip_index;
			phase_d   = stac_pkg::PHASE_SECOND;
			winding_d = 1'b0;
		end else begin
			unique case (phase_q)
				stac_pkg::PHASE_FIRST: begin
					older_d = strip_index;
					phase_d = stac_pkg::PHASE_SECOND;
				end
				stac_pkg::PHASE_SECOND: begin
					newer_d = strip_index;
					phase_d = stac_pkg::PHASE_RUN;
				end
				default: begin
					// running (unused code 3 behaves the same)
					if (strip_index == restart_index) begin
						phase_d            = stac_pkg::PHASE_FIRST;
						winding_d          = 1'b0;
						status.restart_hit = 1'b1;
					end else begin
						winding_d   = ~winding_q;
						status.emit = distinct;
						older_d     = newer_q;
						newer_d     = strip_index;
					end
				end
			endcase
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= stac_pkg::PHASE_FIRST;
			winding_q <= 1'b0;
			older_q   <= '0;
			newer_q   <= '0;
		end else if (advance) begin
			phase_q   <= phase_d;
			winding_q <= winding_d;
			older_q   <= older_d;
			newer_q   <= newer_d;
		end
	end

endmodule

// ===== design/strip_to_triangle_assembler.sv =====
// Top level of the strip to triangle assembler: input and result registers.
// Depends on stac_pkg, stac_cfg_regs, stac_core and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Turns a stream of triangle-strip vertex indices into triangles, one index
// request per clock while results are drained. Each index is registered,
// assembled against the held pair with compares and muxes, and the triangle
// lands in a result register, so tri_valid rises once the index has passed the
// input register and the result register. Indices that give no triangle
// (pair loading, restart, degenerate) pass even while a result is waiting.
// restart_index (APB offset 0x0, reset 0xFFFF) should only be written while
// the block is idle.
module strip_to_triangle_assembler #(
	parameter int unsigned INDEX_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [stac_pkg::ADDR_BITS-1:0] paddr,
	input  logic [stac_pkg::DATA_BITS-1:0] pwdata,
	output logic [stac_pkg::DATA_BITS-1:0] prdata,
	output logic                           pready,
	input  logic                           vertex_valid,
	output logic                           vertex_ready,
	input  logic [INDEX_BITS-1:0]          strip_index,
	input  logic                           strip_start,
	output logic                           tri_valid,
	input  logic                           tri_ready,
	output logic [INDEX_BITS-1:0]          corner_one,
	output logic [INDEX_BITS-1:0]          corner_two,
	output logic [INDEX_BITS-1:0]          corner_three
);

	logic [INDEX_BITS-1:0]  restart_index;
	logic                   valid_s1;
	logic [INDEX_BITS-1:0]  index_s1;
	logic                   start_s1;
	logic                   advance;
	stac_pkg::step_status_t status;
	logic [INDEX_BITS-1:0]  tri_a, tri_b, tri_c;
	logic                   out_valid_q;
	logic [INDEX_BITS-1:0]  corner_one_q, corner_two_q, corner_three_q;

	stac_cfg_regs #(.INDEX_BITS(INDEX_BITS)) u_cfg (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.restart_index (restart_index)
	);

	stac_core #(.INDEX_BITS(INDEX_BITS)) u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (advance),
		.strip_index   (index_s1),
		.strip_start   (start_s1),
		.restart_index (restart_index),
		.status        (status),
		.tri_a         (tri_a),
		.tri_b         (tri_b),
		.tri_c         (tri_c)
	);

	// Head request moves on unless its triangle has nowhere to go
	assign advance      = valid_s1 && (!status.emit || !out_valid_q || tri_ready);
	assign vertex_ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (vertex_valid && vertex_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (vertex_valid && vertex_ready) begin
			index_s1 <= strip_index;
			start_s1 <= strip_start;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && status.emit) begin
			out_valid_q <= 1'b1;
		end else if (tri_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && status.emit) begin
			corner_one_q   <= tri_a;
			corner_two_q   <= tri_b;
			corner_three_q <= tri_c;
		end
	end

	assign tri_valid    = out_valid_q;
	assign corner_one   = corner_one_q;
	assign corner_two   = corner_two_q;
	assign corner_three = corner_three_q;

	// Checks
	`STAC_ASSERT_IMPLIES(a_restart_no_emit, clk, arst_n,
		valid_s1 && status.restart_hit, !status.emit)
	`STAC_ASSERT_NEXT(a_emit_lands, clk, arst_n, advance && status.emit, tri_valid)
	`STAC_ASSERT_IMPLIES(a_corners_distinct, clk, arst_n, tri_valid,
		(corner_one != corner_two) && (corner_two != corner_three)
		&& (corner_one != corner_three))
	`STAC_ASSERT_IMPLIES(a_no_overwrite, clk, arst_n,
		advance && status.emit && tri_valid, tri_ready)

endmodule

// ===== tb/tb_strip_to_triangle_assembler.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for strip_to_triangle_assembler: streams strip index requests,
// predicts the triangles in step and compares every triangle field by field.
// Depends on stac_pkg and the RTL of the block.

module tb_strip_to_triangle_assembler;

	localparam int unsigned INDEX_BITS   = 16;
	localparam int unsigned CYCLE_LIMIT  = 100000;
	localparam int unsigned HOLD_CYCLES  = 400;
	localparam int unsigned DRAIN_CYCLES = 6;
	localparam int unsigned MAX_REPORTS  = 10;
	localparam logic [stac_pkg::ADDR_BITS-1:0] ADDR_RESTART =
		stac_pkg::ADDR_BITS'(4 * int'(stac_pkg::REG_RESTART_INDEX));

	typedef logic [INDEX_BITS-1:0] index_t;
	typedef struct packed {
		index_t idx;
		logic   start;
	} vertex_req_t;
	typedef struct packed {
		index_t one;
		index_t two;
		index_t three;
	} triangle_t;

	// Block ports
	logic                           clk;
	logic                           arst_n;
	logic                           psel;
	logic                           penable;
	logic                           pwrite;
	logic [stac_pkg::ADDR_BITS-1:0] paddr;
	logic [stac_pkg::DATA_BITS-1:0] pwdata;
	logic [stac_pkg::DATA_BITS-1:0] prdata;
	logic                           pready;
	logic                           vertex_valid = 1'b0;
	logic                           vertex_ready;
	index_t                         strip_index  = '0;
	logic                           strip_start  = 1'b0;
	logic                           tri_valid;
	logic                           tri_ready    = 1'b0;
	index_t                         corner_one;
	index_t                         corner_two;
	index_t                         corner_three;

	// Predicted assembly state
	index_t      pair_older;
	index_t      pair_newer;
	index_t      restart_value;
	logic [1:0]  pair_phase;
	logic        next_is_even;
	triangle_t   tri_expect_q[$];
	vertex_req_t pending_q[$];

	// Flow control between processes
	logic        index_taken  = 1'b0;
	logic        steady_flow  = 1'b0;
	logic        hold_request = 1'b0;
	logic        hold_done    = 1'b0;
	int unsigned hold_count   = 0;
	int unsigned cycle_count  = 0;
	int unsigned error_count  = 0;

	strip_to_triangle_assembler #(
		.INDEX_BITS(INDEX_BITS)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.vertex_valid(vertex_valid),
		.vertex_ready(vertex_ready),
		.strip_index (strip_index),
		.strip_start (strip_start),
		.tri_valid   (tri_valid),
		.tri_ready   (tri_ready),
		.corner_one  (corner_one),
		.corner_two  (corner_two),
		.corner_three(corner_three)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Advance the predicted pair by one index request
	task automatic assemble_index(input vertex_req_t r);
		triangle_t t;
		if (r.start) begin
			pair_older   = r.idx;
			pair_phase   = stac_pkg::PHASE_SECOND;
			next_is_even = 1'b0;
		end else if (pair_phase == stac_pkg::PHASE_FIRST) begin
			pair_older = r.idx;
			pair_phase = stac_pkg::PHASE_SECOND;
		end else if (pair_phase == stac_pkg::PHASE_SECOND) begin
			pair_newer = r.idx;
			pair_phase = stac_pkg::PHASE_RUN;
		end else if (r.idx == restart_value) begin
			pair_phase   = stac_pkg::PHASE_FIRST;
			next_is_even = 1'b0;
		end else begin
			// degenerate triangles are dropped but still shift the pair and the winding
			if (pair_older != pair_newer && pair_newer != r.idx && pair_older != r.idx) begin
				t.one   = pair_older;
				t.two   = next_is_even ? r.idx : pair_newer;
				t.three = next_is_even ? pair_newer : r.idx;
				tri_expect_q.push_back(t);
			end
			next_is_even = !next_is_even;
			pair_older   = pair_newer;
			pair_newer   = r.idx;
		end
	endtask

	task automatic report_error(input string msg);
		if (error_count < MAX_REPORTS)
			$display("[%0t] mismatch: %s", $realtime, msg);
		error_count++;
	endtask

	task automatic check_triangle();
		triangle_t want;
		if (tri_expect_q.size() == 0) begin
			report_error($sformatf("triangle %0h,%0h,%0h with none expected",
				corner_one, corner_two, corner_three));
		end else begin
			want = tri_expect_q.pop_front();
			if (corner_one !== want.one)
				report_error($sformatf("corner_one exp %0h got %0h", want.one, corner_one));
			if (corner_two !== want.two)
				report_error($sformatf("corner_two exp %0h got %0h", want.two, corner_two));
			if (corner_three !== want.three)
				report_error($sformatf("corner_three exp %0h got %0h", want.three, corner_three));
		end
	endtask

	// Monitor: sample both handshakes at the rising edge
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		index_taken <= arst_n && vertex_valid && vertex_ready;
		if (arst_n && tri_valid && tri_ready)
			check_triangle();
		if (arst_n && vertex_valid && vertex_ready)
			assemble_index('{idx: strip_index, start: strip_start});
	end

	// Driver: next index request offered at the falling edge
	always @(negedge clk) begin
		vertex_req_t nxt;
		logic        offer;
		if (!vertex_valid || index_taken) begin
			offer = 1'b0;
			if (pending_q.size() != 0 && (steady_flow || $urandom_range(99) >= 33)) begin
				nxt   = pending_q.pop_front();
				offer = 1'b1;
			end
			vertex_valid <= offer;
			if (offer) begin
				strip_index <= nxt.idx;
				strip_start <= nxt.start;
			end
		end
	end

	// Receiver: random stalls, plus one long hold-off to back the block up
	always @(negedge clk) begin
		if (hold_request && !hold_done) begin
			tri_ready <= 1'b0;
			hold_count++;
			if (hold_count >= HOLD_CYCLES)
				hold_done <= 1'b1;
		end else begin
			tri_ready <= steady_flow || ($urandom_range(99) >= 33);
		end
	end

	always @(posedge clk) begin
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic write_register(input logic [stac_pkg::ADDR_BITS-1:0] addr,
		input logic [stac_pkg::DATA_BITS-1:0] value);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = addr;
		pwdata  = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		if (addr == ADDR_RESTART)
			restart_value = value[INDEX_BITS-1:0];
	endtask

	// Wait until every request is taken and every triangle seen, then let the pipe settle
	task automatic wait_drained();
		while (pending_q.size() != 0 || vertex_valid || tri_expect_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic vertex_req_t mk_req(input index_t idx, input logic start);
		mk_req.idx   = idx;
		mk_req.start = start;
	endfunction

	// Mostly well-formed strips with random content; some noise and broken strips
	task automatic queue_strips(input int unsigned count);
		int unsigned n;
		int unsigned len;
		index_t      pool_base;
		logic        narrow;
		vertex_req_t r;
		n = 0;
		while (n < count) begin
			if ($urandom_range(9) == 0) begin
				repeat ($urandom_range(1, 6)) begin
					r = mk_req(index_t'($urandom), 1'($urandom_range(1)));
					pending_q.push_back(r);
					n++;
				end
			end else begin
				len       = $urandom_range(3, 24);
				// a narrow pool makes repeated indices and degenerates common
				narrow    = ($urandom_range(3) == 0);
				pool_base = index_t'($urandom);
				for (int k = 0; k < len; k++) begin
					r.start = (k == 0) ? ($urandom_range(3) != 0) : 1'b0;
					if (k >= 2 && $urandom_range(15) == 0)
						r.idx = restart_value;
					else if (narrow)
						r.idx = pool_base + index_t'($urandom_range(3));
					else
						r.idx = index_t'($urandom);
					pending_q.push_back(r);
					n++;
				end
			end
		end
	endtask

	initial begin
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = '0;
		pwdata  = '0;
		arst_n  = 1'b0;
		pair_older    = '0;
		pair_newer    = '0;
		pair_phase    = stac_pkg::PHASE_FIRST;
		next_is_even  = 1'b0;
		restart_value = stac_pkg::RESTART_DEFAULT[INDEX_BITS-1:0];
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: no strip start after reset, both windings, restarts, degenerates
		pending_q.push_back(mk_req(16'd10, 1'b0));
		pending_q.push_back(mk_req(16'd20, 1'b0));
		pending_q.push_back(mk_req(16'd30, 1'b0));
		pending_q.push_back(mk_req(16'd40, 1'b0));
		pending_q.push_back(mk_req(16'hFFFF, 1'b0)); // restart while running
		pending_q.push_back(mk_req(16'hFFFF, 1'b0)); // restart value loaded as pair
		pending_q.push_back(mk_req(16'hFFFF, 1'b0));
		pending_q.push_back(mk_req(16'd5, 1'b0));    // degenerate, dropped
		pending_q.push_back(mk_req(16'd0, 1'b0));
		pending_q.push_back(mk_req(16'hFFFF, 1'b1)); // strip start on restart value
		pending_q.push_back(mk_req(16'd0, 1'b0));
		pending_q.push_back(mk_req(16'd1, 1'b0));
		pending_q.push_back(mk_req(16'd1, 1'b0));    // shares newer
		pending_q.push_back(mk_req(16'd1, 1'b0));
		pending_q.push_back(mk_req(16'd2, 1'b0));
		pending_q.push_back(mk_req(16'd7, 1'b1));    // strip start mid strip
		pending_q.push_back(mk_req(16'd8, 1'b0));
		pending_q.push_back(mk_req(16'd7, 1'b0));    // shares older
		pending_q.push_back(mk_req(16'd9, 1'b0));
		pending_q.push_back(mk_req(16'hFFFE, 1'b0));
		pending_q.push_back(mk_req(16'hFFFF, 1'b0));
		pending_q.push_back(mk_req(16'd3, 1'b0));
		pending_q.push_back(mk_req(16'd4, 1'b0));
		pending_q.push_back(mk_req(16'hAAAA, 1'b0));
		pending_q.push_back(mk_req(16'h5555, 1'b0));
		wait_drained();

		// Default restart, with the receiver holding off for a long stretch
		hold_request = 1'b1;
		queue_strips(300);
		wait_drained();

		// Restart on zero, no idling on either side
		write_register(ADDR_RESTART, 32'h0000_0000);
		steady_flow = 1'b1;
		queue_strips(280);
		wait_drained();
		steady_flow = 1'b0;

		write_register(ADDR_RESTART, stac_pkg::DATA_BITS'($urandom_range(1, 16'hFFFE)));
		queue_strips(280);
		wait_drained();

		write_register(ADDR_RESTART, stac_pkg::RESTART_DEFAULT);
		queue_strips(280);
		wait_drained();

		if (error_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+design
design/stac_pkg.sv
design/stac_cfg_regs.sv
design/stac_core.sv
design/strip_to_triangle_assembler.sv
tb/tb_strip_to_triangle_assembler.sv
